/* src/mvbcsg_pkg.sv */
package mvbcsg_pkg;

  localparam int unsigned DIV_W = 16;
  localparam logic [DIV_W-1:0] POLY_HI = 16'hE500;
  localparam int unsigned REM_W = 7;

  typedef logic [DIV_W-1:0] div_t;
  typedef logic [7:0] byte_t;

  // eight steps of the left-aligned generator x^7+x^6+x^5+x^2+1
  function automatic div_t reduce8(input div_t r);
    div_t v;
    v = r;
    for (int k = 0; k < 8; k++) begin
      if (v[DIV_W-1]) begin
        v = v ^ POLY_HI;
      end
      v = {v[DIV_W-2:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic parity8(input byte_t b);
    return ^b;
  endfunction

endpackage

/* src/mvb_check_sequence_generator.sv */
// Check-sequence generator for process-data ports: takes one data byte per item and, when a
// group closes (after GROUP_BYTES bytes or on a byte with in_tlast set), delivers one item whose
// byte is the inverted 7-bit CRC remainder (x^7+x^6+x^5+x^2+1) shifted left with even parity
// over the group's data bits and the remainder in bit 0; out_tlast marks the port's last group.
// Bytes that do not close a group produce no output item. The block accepts one byte per cycle:
// an input register and a result register bracket a single pass of reduction and parity logic,
// so a closing byte passes the input register, then the result register; the input only
// stalls when a closing byte waits behind an output item that is not being taken.
module mvb_check_sequence_generator
  import mvbcsg_pkg::*;
#(
  parameter int unsigned GROUP_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tlast,   // last_in_port
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // check_byte
  output logic       out_tlast   // port_done
);

  localparam int unsigned CNT_W = $clog2(GROUP_BYTES);
  localparam logic [CNT_W:0] GROUP_LAST = (CNT_W+1)'(GROUP_BYTES);

  logic             s1_valid_r, s1_valid_nxt;
  byte_t            s1_data_r;
  logic             s1_last_r;
  div_t             div_r, div_nxt;
  logic             par_r, par_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_data_r;
  logic             out_last_r;

  logic             first;
  div_t             merged;
  logic             par_m;
  logic [CNT_W:0]   taken;
  logic             close;
  div_t             fin;
  logic [REM_W-1:0] remain;
  logic             par_f;
  byte_t            chk;
  logic             out_free;
  logic             s1_go;
  logic             in_acc;

  always_comb begin
    first  = (cnt_r == '0);
    merged = first ? {s1_data_r, 8'h00} : reduce8(div_r | {8'h00, s1_data_r});
    par_m  = first ? parity8(s1_data_r) : (par_r ^ parity8(s1_data_r));
    taken  = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};
    close  = s1_last_r || (taken == GROUP_LAST);
    fin    = reduce8(merged);
    remain = fin[DIV_W-1 -: REM_W];
    par_f  = par_m ^ (^remain);
    chk    = ~{remain, par_f};
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!close || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    div_nxt       = div_r;
    par_nxt       = par_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
      if (close) begin
        div_nxt       = '0;
        par_nxt       = 1'b0;
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        div_nxt = merged;
        par_nxt = par_m;
        cnt_nxt = taken[CNT_W-1:0];
      end
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      div_r       <= '0;
      par_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      div_r       <= div_nxt;
      par_r       <= par_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_go && close) begin
      out_data_r <= chk;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/mvbcsg_checker.sv */
module mvbcsg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output item present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_tvalid && out_tready |-> in_tready)
    else $error("input stalled while output item is taken");

endmodule

bind mvb_check_sequence_generator mvbcsg_checker u_mvbcsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
